### src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/mafl_pkg.sv
package mafl_pkg;

	localparam int HDR_W   = 24;
	localparam int FRAME_W = 12;
	localparam int KBPS_W  = 9;
	localparam int COEF_W  = 8;
	localparam int PROD_W  = KBPS_W + COEF_W - 1;  // coef * kbps fits in 16 bits
	localparam int RECIP_W = 29;
	localparam int RECIP_SH = 31;
	localparam int QUOT_W  = PROD_W + RECIP_W - RECIP_SH;

	localparam logic [FRAME_W-1:0] FRAME_MAX = 12'd2881;
	localparam logic [QUOT_W-1:0]  QUOT_MAX  = 14'd8064;

	// version index
	localparam logic [1:0] VER_25   = 2'd0;
	localparam logic [1:0] VER_RSVD = 2'd1;
	localparam logic [1:0] VER_2    = 2'd2;
	localparam logic [1:0] VER_1    = 2'd3;

	// layer index
	localparam logic [1:0] LYR_RSVD = 2'd0;
	localparam logic [1:0] LYR_III  = 2'd1;
	localparam logic [1:0] LYR_II   = 2'd2;
	localparam logic [1:0] LYR_I    = 2'd3;

	// sample-rate index; the rate is base * 1, 2 or 4 by version
	localparam logic [1:0] SR_11K  = 2'd0;
	localparam logic [1:0] SR_12K  = 2'd1;
	localparam logic [1:0] SR_8K   = 2'd2;
	localparam logic [1:0] SR_RSVD = 2'd3;

	// samples / 8 for layer II and III, 12 (= 384 / 32) for layer I
	localparam logic [COEF_W-1:0] COEF_FULL = 8'd144;
	localparam logic [COEF_W-1:0] COEF_HALF = 8'd72;
	localparam logic [COEF_W-1:0] COEF_L1   = 8'd12;

	// x*1000/base as (x * K) >> 31, exact over the product range
	localparam logic [RECIP_W-1:0] RECIP_11K = 29'd194783120;  // 40 * ceil(2^31/441)
	localparam logic [RECIP_W-1:0] RECIP_12K = 29'd178956971;  // ceil(2^31/12)
	localparam logic [RECIP_W-1:0] RECIP_8K  = 29'd268435456;  // 2^31/8

	localparam logic [KBPS_W-1:0] KBPS_V1_L3 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [KBPS_W-1:0] KBPS_V1_L2 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [KBPS_W-1:0] KBPS_V1_L1 [16] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [KBPS_W-1:0] KBPS_V2_L23 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
	localparam logic [KBPS_W-1:0] KBPS_V2_L1 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};

	typedef struct packed {
		logic       ok;
		logic [1:0] base_sel;
		logic [1:0] shift;
		logic       pad;
		logic       layer1;
	} post_t;

	typedef struct packed {
		post_t              post;
		logic [KBPS_W-1:0]  kbps;
		logic [COEF_W-1:0]  coef;
	} dec_t;

	function automatic logic [KBPS_W-1:0] kbps_lookup(input logic is_v1,
			input logic [1:0] lyr, input logic [3:0] brx);
		logic [KBPS_W-1:0] r;
		r = '0;
		unique case (lyr)
			LYR_III: r = is_v1 ? KBPS_V1_L3[brx] : KBPS_V2_L23[brx];
			LYR_II:  r = is_v1 ? KBPS_V1_L2[brx] : KBPS_V2_L23[brx];
			LYR_I:   r = is_v1 ? KBPS_V1_L1[brx] : KBPS_V2_L1[brx];
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] sel);
		logic [RECIP_W-1:0] r;
		r = RECIP_8K;
		unique case (sel)
			SR_11K:  r = RECIP_11K;
			SR_12K:  r = RECIP_12K;
			default: r = RECIP_8K;
		endcase
		return r;
	endfunction

endpackage

### src/mafl_decode.sv
module mafl_decode import mafl_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [HDR_W-1:0] header_bytes,
	output dec_t             dec_s1
);

	logic [7:0] b0, b1, b2;
	logic [1:0] ver, lyr, srx;
	logic [3:0] brx;
	dec_t       dec_d;

	assign b0  = header_bytes[23:16];
	assign b1  = header_bytes[15:8];
	assign b2  = header_bytes[7:0];
	assign ver = b1[4:3];
	assign lyr = b1[2:1];
	assign brx = b2[7:4];
	assign srx = b2[3:2];

	always_comb begin
		dec_d.post.ok = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (ver != VER_RSVD)
			&& (lyr != LYR_RSVD) && (brx != 4'hF) && (brx != 4'h0) && (srx != SR_RSVD);
		dec_d.post.base_sel = srx;
		dec_d.post.pad      = b2[1];
		dec_d.post.layer1   = (lyr == LYR_I);
		unique case (ver)
			VER_1:   dec_d.post.shift = 2'd2;
			VER_2:   dec_d.post.shift = 2'd1;
			default: dec_d.post.shift = 2'd0;
		endcase
		dec_d.kbps = kbps_lookup(ver == VER_1, lyr, brx);
		if (lyr == LYR_I) begin
			dec_d.coef = COEF_L1;
		end else if (lyr == LYR_II || ver == VER_1) begin
			dec_d.coef = COEF_FULL;
		end else begin
			dec_d.coef = COEF_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

### src/mafl_scale.sv
module mafl_scale import mafl_pkg::*; (
	input  logic              clk,
	input  logic              en2,
	input  logic              en3,
	input  dec_t              dec_s1,
	output logic [QUOT_W-1:0] quot_s3,
	output post_t             post_s3
);

	logic [PROD_W-1:0]                prod_s2;
	post_t                            post_s2;
	logic [PROD_W+RECIP_W-1:0]        scaled;

	// divide by the base rate through a constant reciprocal
	assign scaled = prod_s2 * recip_lookup(post_s2.base_sel);

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= PROD_W'(dec_s1.coef * dec_s1.kbps);
			post_s2 <= dec_s1.post;
		end
		if (en3) begin
			quot_s3 <= scaled[PROD_W+RECIP_W-1:RECIP_SH];
			post_s3 <= post_s2;
		end
	end

endmodule

### src/mpeg_audio_frame_length_unit.sv
// MPEG audio frame length: takes the first three header bytes (byte 0 in
// bits 23..16) and returns the frame length in bytes, or zero for lost
// sync, a reserved version, layer, bitrate or sample-rate index, and for
// free-format bitrate. Four register stages (decode and table lookup,
// coefficient times bitrate, reciprocal multiply by the base rate, version
// shift and padding), and one header is accepted every cycle while
// out_stall is low. Each stage holds on its own when the next one is
// full, so bubbles close up under output stall.
`include "assert_macros.svh"

module mpeg_audio_frame_length_unit import mafl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [HDR_W-1:0]   header_bytes,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FRAME_W-1:0] frame_bytes
);

	logic                v1_q, v2_q, v3_q, v4_q;
	logic                ld1, ld2, ld3, ld4;
	dec_t                dec_s1;
	logic [QUOT_W-1:0]   quot_s3;
	post_t               post_s3;
	logic [QUOT_W-1:0]   quot_sh;
	logic [QUOT_W:0]     slots;
	logic [QUOT_W+2:0]   len;
	logic [FRAME_W-1:0]  frame_s4;

	assign ld4 = !v4_q || !out_stall;
	assign ld3 = !v3_q || ld4;
	assign ld2 = !v2_q || ld3;
	assign ld1 = !v1_q || ld2;

	assign in_stall    = !ld1;
	assign out_valid   = v4_q;
	assign frame_bytes = frame_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= in_valid;
			if (ld2) v2_q <= v1_q;
			if (ld3) v3_q <= v2_q;
			if (ld4) v4_q <= v3_q;
		end
	end

	mafl_decode u_decode (
		.clk          (clk),
		.en           (ld1 && in_valid),
		.header_bytes (header_bytes),
		.dec_s1       (dec_s1)
	);

	mafl_scale u_scale (
		.clk     (clk),
		.en2     (ld2 && v1_q),
		.en3     (ld3 && v2_q),
		.dec_s1  (dec_s1),
		.quot_s3 (quot_s3),
		.post_s3 (post_s3)
	);

	// rate = base * 2^shift; layer I counts 4-byte slots
	always_comb begin
		quot_sh = quot_s3 >> post_s3.shift;
		slots   = {1'b0, quot_sh} + (QUOT_W+1)'(post_s3.pad);
		len     = post_s3.layer1 ? {slots, 2'b00} : {2'b00, slots};
	end

	always_ff @(posedge clk) begin
		if (ld4 && v3_q) begin
			frame_s4 <= post_s3.ok ? len[FRAME_W-1:0] : '0;
		end
	end

	`ASSERT_IMPLIES(a_full_stalls_input, clk, arst_n, v1_q && v2_q && v3_q && v4_q && out_stall, in_stall)
	`ASSERT_IMPLIES(a_quot_range, clk, arst_n, v3_q && post_s3.ok, quot_s3 <= QUOT_MAX)
	`ASSERT_IMPLIES(a_frame_range, clk, arst_n, out_valid, frame_bytes <= FRAME_MAX)
	`ASSERT_NEXT(a_held_result_stays, clk, arst_n, v3_q && v4_q && out_stall, v4_q && v3_q)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mafl_pkg::*;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [2:0] SYNC_TOP  = 3'b111;
	localparam logic [3:0] BRX_FREE  = 4'h0;
	localparam logic [3:0] BRX_RSVD  = 4'hF;
	localparam int N_RANDOM = 1600;
	localparam int HOLD_CYCLES = 120;

	localparam int unsigned MPEG1_L3_KBPS [16] = '{
		0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
	localparam int unsigned MPEG1_L2_KBPS [16] = '{
		0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
	localparam int unsigned MPEG1_L1_KBPS [16] = '{
		0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
	localparam int unsigned MPEG2_L23_KBPS [16] = '{
		0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
	localparam int unsigned MPEG2_L1_KBPS [16] = '{
		0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [HDR_W-1:0]   header_bytes = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FRAME_W-1:0] frame_bytes;

	logic [HDR_W-1:0]   header_q [$];
	logic [FRAME_W-1:0] frame_bytes_q [$];
	logic [FRAME_W-1:0] want_bytes;
	int n_total = 0;
	int n_taken = 0;
	int n_errors = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	mpeg_audio_frame_length_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.header_bytes (header_bytes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_bytes  (frame_bytes)
	);

	function automatic logic [FRAME_W-1:0] calc_frame_bytes(input logic [HDR_W-1:0] h);
		logic [1:0] ver;
		logic [1:0] lyr;
		logic [1:0] srx;
		logic [3:0] brx;
		logic pad;
		int unsigned kbps;
		int unsigned rate;
		int unsigned bps;
		int unsigned len;
		ver = h[12:11];
		lyr = h[10:9];
		brx = h[7:4];
		srx = h[3:2];
		pad = h[1];
		if (h[23:16] != SYNC_BYTE || h[15:13] != SYNC_TOP)
			return '0;
		if (ver == VER_RSVD || lyr == LYR_RSVD || brx == BRX_FREE || brx == BRX_RSVD ||
				srx == SR_RSVD)
			return '0;
		case (lyr)
			LYR_III: kbps = (ver == VER_1) ? MPEG1_L3_KBPS[brx] : MPEG2_L23_KBPS[brx];
			LYR_II:  kbps = (ver == VER_1) ? MPEG1_L2_KBPS[brx] : MPEG2_L23_KBPS[brx];
			default: kbps = (ver == VER_1) ? MPEG1_L1_KBPS[brx] : MPEG2_L1_KBPS[brx];
		endcase
		case (srx)
			SR_11K:  rate = 11025;
			SR_12K:  rate = 12000;
			default: rate = 8000;
		endcase
		if (ver == VER_1)
			rate = rate * 4;
		else if (ver == VER_2)
			rate = rate * 2;
		bps = kbps * 1000;
		if (lyr == LYR_I)
			len = ((12 * bps) / rate + pad) * 4;
		else if (lyr == LYR_II || ver == VER_1)
			len = (144 * bps) / rate + pad;
		else
			len = (72 * bps) / rate + pad;
		return len[FRAME_W-1:0];
	endfunction

	function automatic logic [HDR_W-1:0] make_header(input logic [1:0] ver,
			input logic [1:0] lyr, input logic [3:0] brx, input logic [1:0] srx,
			input logic pad, input logic [1:0] misc);
		return {SYNC_BYTE, SYNC_TOP, ver, lyr, misc[1], brx, srx, pad, misc[0]};
	endfunction

	// 0: sender idles less, 1: receiver idles less, 2: no idling
	function automatic int idle_phase();
		if (n_taken < n_total / 3)
			return 0;
		else if (n_taken < 2 * n_total / 3)
			return 1;
		return 2;
	endfunction

	function automatic int send_idle_pct();
		case (idle_phase())
			0: return 20;
			1: return 47;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (idle_phase())
			0: return 47;
			1: return 20;
			default: return 0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// header source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			header_bytes <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_bytes_q.push_back(calc_frame_bytes(header_bytes));
				n_taken <= n_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (header_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
					in_valid <= 1'b1;
					header_bytes <= header_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, with one long hold once traffic runs freely
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_taken >= 3 * n_total / 4) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frame_bytes_q.size() == 0) begin
				$error("frame_bytes: no transfer expected, actual %0d", frame_bytes);
				n_errors++;
			end else begin
				want_bytes = frame_bytes_q.pop_front();
				if (frame_bytes !== want_bytes) begin
					$error("frame_bytes: expected %0d, actual %0d", want_bytes, frame_bytes);
					n_errors++;
				end
			end
		end
	end

	initial begin
		int pick;
		logic [1:0] ver;

		// largest frame, top layer I rate, free format with padding, then reserved bitrate, version, layer and sample-rate
		header_q.push_back(make_header(VER_25, LYR_II, 4'd14, SR_8K, 1'b1, 2'b00));
		header_q.push_back(make_header(VER_1, LYR_I, 4'd14, SR_8K, 1'b1, 2'b11));
		header_q.push_back(make_header(VER_1, LYR_III, BRX_FREE, SR_11K, 1'b1, 2'b00));
		header_q.push_back(make_header(VER_1, LYR_III, BRX_RSVD, SR_11K, 1'b0, 2'b00));
		header_q.push_back(make_header(VER_RSVD, LYR_III, 4'd9, SR_11K, 1'b0, 2'b00));
		header_q.push_back(make_header(VER_1, LYR_RSVD, 4'd9, SR_11K, 1'b0, 2'b00));
		header_q.push_back(make_header(VER_1, LYR_III, 4'd9, SR_RSVD, 1'b1, 2'b00));
		// lost sync in byte 0 and in byte 1, then all zeros and all ones
		header_q.push_back({8'hFE, 16'hFB90});
		header_q.push_back({SYNC_BYTE, 3'b110, 13'h1B90});
		header_q.push_back('0);
		header_q.push_back('1);
		header_q.push_back(make_header(VER_1, LYR_III, 4'd9, SR_11K, 1'b0, 2'b00));
		header_q.push_back(make_header(VER_1, LYR_III, 4'd1, SR_11K, 1'b1, 2'b11));
		header_q.push_back(make_header(VER_1, LYR_II, 4'd14, SR_12K, 1'b1, 2'b01));
		header_q.push_back(make_header(VER_2, LYR_III, 4'd14, SR_8K, 1'b1, 2'b10));
		header_q.push_back(make_header(VER_2, LYR_II, 4'd1, SR_11K, 1'b0, 2'b00));
		header_q.push_back(make_header(VER_2, LYR_I, 4'd14, SR_12K, 1'b1, 2'b11));
		header_q.push_back(make_header(VER_25, LYR_III, 4'd14, SR_8K, 1'b1, 2'b00));
		header_q.push_back(make_header(VER_25, LYR_I, 4'd1, SR_11K, 1'b0, 2'b01));
		header_q.push_back(make_header(VER_25, LYR_II, 4'd7, SR_12K, 1'b1, 2'b10));

		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				case ($urandom_range(0, 2))
					0: ver = VER_25;
					1: ver = VER_2;
					default: ver = VER_1;
				endcase
				header_q.push_back(make_header(ver, 2'($urandom_range(1, 3)),
					4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
					1'($urandom), 2'($urandom)));
			end else if (pick < 95) begin
				header_q.push_back({SYNC_BYTE, SYNC_TOP, 13'($urandom)});
			end else begin
				header_q.push_back(HDR_W'($urandom));
			end
		end
		n_total = header_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_total || frame_bytes_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
